/* hdl/utf8_pkg.sv */
// Shared types, constants and lead byte classification for the UTF-8 to UCS-2 decoder.
package utf8_pkg;

    localparam logic [1:0] KIND_UNIT  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [15:0] CODE_WIDE   = 16'hFF1F;
    localparam logic [7:0]  BOM_BYTE0   = 8'hEF;
    localparam logic [7:0]  BOM_BYTE1   = 8'hBB;
    localparam logic [7:0]  BOM_BYTE2   = 8'hBF;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;
    localparam logic [2:0] LEN_FIVE  = 3'd5;
    localparam logic [2:0] LEN_SIX   = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    // Results caused by one byte: an optional first item, then an optional end-of-string item.
    typedef struct packed {
        logic [15:0] code;
        logic [1:0]  kind;
        logic        has_unit;
        logic        has_end;
    } pair_t;

    // Sequence length from a lead byte; LEN_NONE for a byte that cannot lead.
    function automatic logic [2:0] lead_class(input logic [7:0] b);
        logic [2:0] len;
        priority if (b < 8'h80) len = LEN_ONE;
        else if (b < 8'hC0)     len = LEN_NONE;
        else if (b < 8'hE0)     len = LEN_TWO;
        else if (b < 8'hF0)     len = LEN_THREE;
        else if (b < 8'hF8)     len = LEN_FOUR;
        else if (b < 8'hFC)     len = LEN_FIVE;
        else if (b < 8'hFE)     len = LEN_SIX;
        else                    len = LEN_NONE;
        return len;
    endfunction

endpackage

/* hdl/utf8_to_ucs2_decoder_core.sv */
// UTF-8 to UCS-2 decoder: per-byte decode into a two-entry result queue.
// Each result is registered in the result queue and is valid on m_tvalid once it reaches the queue head.
// Throughput: one byte per cycle while the result queue is not full; a byte with two results (unit
// plus end) is sent as two items in turn, as the single result port drains the queue.
// Reset (aresetn low, synchronous): no sequence open, string start expected,
// result queue empty.
module utf8_to_ucs2_decoder_core
    import utf8_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic [1:0]  m_tuser,   // [1:0] item_kind
    output logic        m_tlast    // last_of_string
);

    logic [2:0]  seq_length_reg, seq_length_next;
    logic [2:0]  bytes_held_reg, bytes_held_next;
    logic [15:0] partial_code_reg, partial_code_next;
    logic        at_start_reg, at_start_next;
    logic        mark_reg, mark_next;
    logic        discard_reg, discard_next;

    pair_t       queue_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        phase_reg;

    pair_t       pair_new;
    logic [2:0]  len;
    logic        complete;
    logic        drop;
    logic        push, pop, s_xfer, m_xfer;
    pair_t       head;

    assign s_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        seq_length_next   = seq_length_reg;
        bytes_held_next   = bytes_held_reg;
        partial_code_next = partial_code_reg;
        at_start_next     = at_start_reg;
        mark_next         = mark_reg;
        discard_next      = discard_reg;
        pair_new          = '0;
        len               = lead_class(s_tdata);
        complete          = 1'b0;
        drop              = 1'b0;

        if (discard_reg) begin
            if (s_tlast) begin
                discard_next  = 1'b0;
                at_start_next = 1'b1;
            end
        end else if (seq_length_reg == LEN_NONE && len == LEN_NONE) begin
            // bad lead: report and drop the rest of the string
            pair_new.kind     = KIND_ERROR;
            pair_new.has_unit = 1'b1;
            seq_length_next   = LEN_NONE;
            bytes_held_next   = 3'd0;
            partial_code_next = '0;
            mark_next         = 1'b0;
            at_start_next     = s_tlast;
            discard_next      = !s_tlast;
        end else begin
            if (seq_length_reg == LEN_NONE) begin
                seq_length_next = len;
                bytes_held_next = 3'd1;
                mark_next       = at_start_reg && (s_tdata == BOM_BYTE0) && !s_tlast;
                unique case (len)
                    LEN_ONE:   partial_code_next = {8'b0, s_tdata};
                    LEN_TWO:   partial_code_next = {5'b0, s_tdata[4:0], 6'b0};
                    LEN_THREE: partial_code_next = {s_tdata[3:0], 12'b0};
                    default:   partial_code_next = '0;
                endcase
            end else begin
                if (seq_length_reg == LEN_TWO) begin
                    partial_code_next = partial_code_reg | {10'b0, s_tdata[5:0]};
                end else if (seq_length_reg == LEN_THREE) begin
                    if (bytes_held_reg == 3'd1) begin
                        partial_code_next = partial_code_reg | {4'b0, s_tdata[5:0], 6'b0};
                        if (s_tdata != BOM_BYTE1) mark_next = 1'b0;
                    end else begin
                        partial_code_next = partial_code_reg | {10'b0, s_tdata[5:0]};
                        if (s_tdata != BOM_BYTE2) mark_next = 1'b0;
                    end
                end
                bytes_held_next = bytes_held_reg + 3'd1;
            end
            at_start_next = 1'b0;

            complete = (bytes_held_next >= seq_length_next) || s_tlast;
            drop     = mark_next && (seq_length_next == LEN_THREE)
                       && (bytes_held_next == 3'd3);
            if (complete) begin
                pair_new.code     = (seq_length_next >= LEN_FOUR) ? CODE_WIDE
                                                                  : partial_code_next;
                pair_new.kind     = KIND_UNIT;
                pair_new.has_unit = !drop;
                seq_length_next   = LEN_NONE;
                bytes_held_next   = 3'd0;
                partial_code_next = '0;
                mark_next         = 1'b0;
            end
            if (s_tlast) begin
                pair_new.has_end = 1'b1;
                at_start_next    = 1'b1;
            end
        end
    end

    // hold only bytes that cause at least one result
    assign push = s_xfer && (pair_new.has_unit || pair_new.has_end);

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 2'd0);
    assign m_xfer   = m_tvalid && m_tready;

    always_comb begin
        if (head.has_unit && !phase_reg) begin
            m_tdata = head.code;
            m_tuser = head.kind;
            m_tlast = (head.kind == KIND_ERROR);
        end else begin
            m_tdata = '0;
            m_tuser = KIND_DONE;
            m_tlast = 1'b1;
        end
    end

    // advance past the head once its final item transfers
    assign pop = m_xfer && (!head.has_end || phase_reg || !head.has_unit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg <= LEN_NONE;
            bytes_held_reg <= 3'd0;
            at_start_reg   <= 1'b1;
            mark_reg       <= 1'b0;
            discard_reg    <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
            phase_reg      <= 1'b0;
        end else begin
            if (s_xfer) begin
                seq_length_reg <= seq_length_next;
                bytes_held_reg <= bytes_held_next;
                at_start_reg   <= at_start_next;
                mark_reg       <= mark_next;
                discard_reg    <= discard_next;
            end
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                phase_reg <= 1'b0;
            end else if (m_xfer) begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_code_reg <= '0;
        end else if (s_xfer) begin
            partial_code_reg <= partial_code_next;
        end
        if (push) queue_reg[wr_ptr_reg] <= pair_new;
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (m_tvalid && head.has_unit && head.has_end))
        else $error("second-item phase without a two-result head");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_UNIT) |-> !m_tlast)
        else $error("code unit marked as last of string");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_length_reg != LEN_NONE) |-> (!discard_reg && bytes_held_reg != 3'd0
                                          && bytes_held_reg < seq_length_reg))
        else $error("open sequence state inconsistent");
`endif

endmodule
